/* design/cpr_pkg.sv */
// Package for the CRC-checked packet receiver.
// Frame constants, controller state type and control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package cpr_pkg;

   localparam int BYTE_W            = 8;
   localparam int CRC_W             = 16;
   localparam int OUT_BYTES         = 4;
   localparam int RSP_W             = OUT_BYTES * BYTE_W + CRC_W;
   localparam int BIT_CNT_W         = 3;
   localparam int DEF_PAYLOAD_BYTES = 4;

   localparam logic [BYTE_W-1:0]    HDR_BYTE  = 8'hFF;
   localparam logic [BYTE_W-1:0]    TRL_BYTE  = 8'hFE;
   localparam logic [CRC_W-1:0]     CRC_INIT  = 16'hFFFF;
   localparam logic [CRC_W-1:0]     CRC_POLY  = 16'hA001;
   localparam logic [BIT_CNT_W-1:0] BIT_LAST  = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAYLOAD,
      ST_CRC_RUN,
      ST_CRC_LO,
      ST_CRC_HI,
      ST_TRAILER
   } state_type;

   typedef struct packed {
      logic hdr_start;
      logic load_byte;
      logic crc_step;
      logic take_lo;
      logic take_hi;
      logic check;
   } cmd_type;

   typedef struct packed {
      logic hdr_match;
      logic bit_last;
      logic payload_done;
      logic out_busy;
   } status_type;

endpackage

/* design/cpr_datapath.sv */
// Datapath of the packet receiver: payload store, bit-serial CRC-16,
// received CRC holds and the result register.
// Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_datapath import cpr_pkg::*; #(
   parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] rx_byte,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int IDX_W = (CNT_W > 2) ? CNT_W : 3;

   logic [CRC_W-1:0]     crc_ff, crc_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [BYTE_W-1:0]    lo_ff, hi_ff;
   logic [BYTE_W-1:0]    store_ff [OUT_BYTES];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff;
   logic [RSP_W-1:0]     rsp_data_next;
   logic                 emit;

   always_comb begin
      crc_in     = crc_ff;
      idx_in     = idx_ff;
      bit_cnt_in = bit_cnt_ff;
      if (cmd.hdr_start) begin
         crc_in = CRC_INIT;
         idx_in = '0;
      end else if (cmd.load_byte) begin
         crc_in     = crc_ff ^ {{(CRC_W-BYTE_W){1'b0}}, rx_byte};
         idx_in     = idx_ff + IDX_W'(1);
         bit_cnt_in = '0;
      end else if (cmd.crc_step) begin
         crc_in     = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
         bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
      end
   end

   assign emit = cmd.check && (rx_byte == TRL_BYTE) && (crc_ff == {hi_ff, lo_ff});

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   for (genvar k = 0; k < OUT_BYTES; k++) begin : g_out
      if (k < PAYLOAD_BYTES) begin : g_used
         assign rsp_data_next[k*BYTE_W +: BYTE_W] = store_ff[k];
      end else begin : g_zero
         assign rsp_data_next[k*BYTE_W +: BYTE_W] = '0;
      end
   end
   assign rsp_data_next[RSP_W-1 -: CRC_W] = {hi_ff, lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         idx_ff       <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         idx_ff       <= idx_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte && (idx_ff < IDX_W'(OUT_BYTES))) begin
         store_ff[idx_ff[1:0]] <= rx_byte;
      end
      if (cmd.take_lo) begin
         lo_ff <= rx_byte;
      end
      if (cmd.take_hi) begin
         hi_ff <= rx_byte;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_next;
      end
   end

   assign status.hdr_match    = (rx_byte == HDR_BYTE);
   assign status.bit_last     = (bit_cnt_ff == BIT_LAST);
   assign status.payload_done = (idx_ff == IDX_W'(PAYLOAD_BYTES));
   assign status.out_busy     = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* design/cpr_ctrl.sv */
// Frame controller of the packet receiver: tracks frame position and
// sequences the bit-serial CRC. Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_ctrl import cpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      accept     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept && status.hdr_match) begin
               cmd.hdr_start = 1'b1;
               state_in      = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               cmd.load_byte = 1'b1;
               state_in      = ST_CRC_RUN;
            end
         end
         ST_CRC_RUN: begin
            cmd.crc_step = 1'b1;
            if (status.bit_last) begin
               state_in = status.payload_done ? ST_CRC_LO : ST_PAYLOAD;
            end
         end
         ST_CRC_LO: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               cmd.take_lo = 1'b1;
               state_in    = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               cmd.take_hi = 1'b1;
               state_in    = ST_TRAILER;
            end
         end
         ST_TRAILER: begin
            // result slot must be free before the frame can complete
            req_tready = !status.out_busy;
            accept     = req_tvalid && req_tready;
            if (accept) begin
               cmd.check = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/crc_checked_packet_receiver_core.sv */
// Top level of the CRC-checked packet receiver (0xFF, payload, CRC lo/hi, 0xFE).
// Instantiates cpr_ctrl and cpr_datapath; depends on cpr_pkg.
//
// channel | dir | transfer
// req     | in  | one received byte, tdata[7:0] = rx_byte
// rsp     | out | one verified packet, data bytes 0..3 then packet_crc
//
// Header, CRC and trailer bytes need only their transfer. A payload byte is
// taken, then shifted bit by bit through the CRC-16 unit while req_tready is low.
// A good frame shows on rsp the cycle after its trailer transfer and is held
// until taken; a trailer is not taken while an earlier result still waits.
// Synchronous reset returns to header search with no result pending.
`timescale 1ns / 1ps

module crc_checked_packet_receiver_core import cpr_pkg::*; #(
   parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // data_byte_0..3 [31:0], packet_crc [47:32]
);

   cmd_type    cmd;
   status_type status;

   cpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cpr_datapath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* tb/sv/cpr_frame_checker.sv */
// Frame checker for the CRC-checked packet receiver: a CRC-16/MODBUS helper
// package and a monitor that predicts packets from req transfers and checks rsp.
// Depends on cpr_pkg.
`timescale 1ns / 1ps

package cpr_tb_pkg;
   import cpr_pkg::*;

   typedef logic [DEF_PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload_type;

   function automatic logic [CRC_W-1:0] modbus_crc(input payload_type pl);
      logic [CRC_W-1:0] acc;
      acc = CRC_INIT;
      for (int k = 0; k < DEF_PAYLOAD_BYTES; k++) begin
         acc = acc ^ {8'h00, pl[k]};
         for (int b = 0; b < 8; b++)
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction
endpackage

module cpr_frame_checker import cpr_pkg::*; import cpr_tb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   output int                error_count,
   output int                pending_count,
   output int                packet_count
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_TRAILER
   } frame_phase_type;

   frame_phase_type  phase = PH_HEADER;
   int unsigned      byte_idx = 0;
   payload_type      payload = '0;
   logic [BYTE_W-1:0] crc_lo = '0;
   logic [BYTE_W-1:0] crc_hi = '0;
   logic [RSP_W-1:0] expected_packets [$];
   int               errors = 0;
   int               matched = 0;

   function automatic void absorb_byte(input logic [BYTE_W-1:0] rx);
      logic [CRC_W-1:0] rx_crc;
      logic [RSP_W-1:0] pkt;
      case (phase)
         PH_PAYLOAD: begin
            if (byte_idx < DEF_PAYLOAD_BYTES) payload[byte_idx] = rx;
            byte_idx++;
            if (byte_idx >= DEF_PAYLOAD_BYTES) phase = PH_CRC_LO;
         end
         PH_CRC_LO: begin
            crc_lo = rx;
            phase  = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            crc_hi = rx;
            phase  = PH_TRAILER;
         end
         PH_TRAILER: begin
            rx_crc = {crc_hi, crc_lo};
            if (rx == TRL_BYTE && modbus_crc(payload) == rx_crc) begin
               pkt = '0;
               for (int j = 0; j < OUT_BYTES; j++)
                  if (j < DEF_PAYLOAD_BYTES) pkt[j*BYTE_W +: BYTE_W] = payload[j];
               pkt[OUT_BYTES*BYTE_W +: CRC_W] = rx_crc;
               expected_packets.push_back(pkt);
            end
            phase = PH_HEADER;
         end
         default: begin
            phase = PH_HEADER;
            if (rx == HDR_BYTE) begin
               phase    = PH_PAYLOAD;
               byte_idx = 0;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         phase    = PH_HEADER;
         byte_idx = 0;
         crc_lo   = '0;
         crc_hi   = '0;
         expected_packets.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_packets.size() == 0) begin
               $display("%0t: packet expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_packets.pop_front();
               for (int j = 0; j < OUT_BYTES; j++)
                  if (rsp_tdata[j*BYTE_W +: BYTE_W] !== want[j*BYTE_W +: BYTE_W]) begin
                     $display("%0t: data_byte_%0d expected %h actual %h", $time, j,
                              want[j*BYTE_W +: BYTE_W], rsp_tdata[j*BYTE_W +: BYTE_W]);
                     errors++;
                  end
               if (rsp_tdata[OUT_BYTES*BYTE_W +: CRC_W] !== want[OUT_BYTES*BYTE_W +: CRC_W])
               begin
                  $display("%0t: packet_crc expected %h actual %h", $time,
                           want[OUT_BYTES*BYTE_W +: CRC_W],
                           rsp_tdata[OUT_BYTES*BYTE_W +: CRC_W]);
                  errors++;
               end
               matched++;
            end
         end
         if (req_tvalid && req_tready) absorb_byte(req_tdata);
      end
      error_count   <= errors;
      pending_count <= expected_packets.size();
      packet_count  <= matched;
   end

endmodule

/* tb/sv/crc_checked_packet_receiver_core_tb.sv */
// Top of the receiver testbench: clock, reset, byte and frame stimulus with
// random gaps and stalls, and the verdict. Depends on cpr_pkg, cpr_tb_pkg and
// cpr_frame_checker.
`timescale 1ns / 1ps

module crc_checked_packet_receiver_core_tb import cpr_pkg::*; import cpr_tb_pkg::*;;

   localparam int BYTE_TARGET = 1050;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 20;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   int error_count;
   int pending_count;
   int packet_count;
   int cycle_count = 0;
   int bytes_sent  = 0;
   int good_frames = 0;
   int bad_trailer = 0;
   int bad_crc     = 0;
   bit no_idle     = 1'b0;

   crc_checked_packet_receiver_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cpr_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .packet_count  (packet_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame(input payload_type pl, input logic [CRC_W-1:0] crc,
                             input logic [BYTE_W-1:0] trailer);
      send_byte(HDR_BYTE);
      for (int k = 0; k < DEF_PAYLOAD_BYTES; k++) send_byte(pl[k]);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      send_byte(trailer);
   endtask

   task automatic drain_packets();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return TRL_BYTE;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // receiver side: random stall before each packet
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d packets outstanding", cycle_count, pending_count);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      payload_type      pl;
      logic [CRC_W-1:0] crc;
      logic [BYTE_W-1:0] trl;
      int               frames;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored bytes while idle, extreme payload, both drop cases
      send_byte(8'h00);
      send_byte(TRL_BYTE);
      pl = {8'h7F, 8'h80, 8'hFF, 8'h00};
      send_frame(pl, modbus_crc(pl), TRL_BYTE);
      good_frames++;
      pl = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame(pl, modbus_crc(pl), 8'h7E);
      bad_trailer++;
      pl = {8'h00, 8'h00, 8'h00, 8'h00};
      send_frame(pl, modbus_crc(pl) ^ 16'h0001, TRL_BYTE);
      bad_crc++;
      drain_packets();

      frames = 0;
      while (bytes_sent < BYTE_TARGET) begin
         if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
         for (int k = 0; k < DEF_PAYLOAD_BYTES; k++) pl[k] = pick_byte();
         crc = modbus_crc(pl);
         case ($urandom_range(0, 9))
            0: begin
               send_frame(pl, crc ^ (16'h0001 << $urandom_range(0, 15)), TRL_BYTE);
               bad_crc++;
            end
            1: begin
               trl = BYTE_W'($urandom);
               if (trl == TRL_BYTE) trl = 8'h00;
               send_frame(pl, crc, trl);
               bad_trailer++;
            end
            2: repeat ($urandom_range(1, 3)) send_byte(pick_byte());
            3: send_frame(pl, CRC_W'($urandom), pick_byte());
            default: begin
               send_frame(pl, crc, TRL_BYTE);
               good_frames++;
            end
         endcase
         frames++;
         if (frames == 60) drain_packets();
      end

      no_idle = 1'b0;
      drain_packets();
      repeat (DRAIN) @(posedge clock);

      $display("sent %0d bytes: %0d good frames, %0d wrong-trailer, %0d bad-CRC, plus noise",
               bytes_sent, good_frames, bad_trailer, bad_crc);
      $display("%0d packets compared, %0d mismatches", packet_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
